@@ hw/rtl/dgf_pkg.sv @@
// Shared types and constants for the decimal glyph formatter.
// Holds the pipeline word carried along the cell chain and the glyph codes.
// No dependencies.
`timescale 1ns / 1ps

package dgf_pkg;

   localparam int NUM_W    = 17;
   localparam int DIGITS   = 5;
   localparam int BCD_W    = 4 * DIGITS;
   localparam int GLYPHS   = 5;
   localparam int GLYPH_W  = 5;
   localparam int LEAD_W   = 3;

   localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 5'd0;
   localparam logic [GLYPH_W-1:0] GLYPH_POINT = 5'd14;
   localparam logic [GLYPH_W-1:0] GLYPH_DIGIT = 5'd16;

   localparam logic [NUM_W-1:0] INT_LIMIT = 17'd99999;

   localparam logic CMD_INT   = 1'b0;
   localparam logic CMD_FIXED = 1'b1;

   // one word in flight: mode, digits built so far, binary bits left to shift in
   typedef struct packed {
      logic             cmd;
      logic [BCD_W-1:0] bcd;
      logic [NUM_W-1:0] bin;
   } dgf_word_type;

   typedef logic [GLYPHS-1:0][GLYPH_W-1:0] dgf_glyphs_type;

   function automatic logic [GLYPH_W-1:0] digit_glyph(input logic [3:0] digit);
      digit_glyph = GLYPH_DIGIT + {1'b0, digit};
   endfunction

endpackage

@@ hw/rtl/dgf_cell.sv @@
// One double-dabble cell: adjusts each digit by three where needed and
// shifts in the next binary bit, with its own valid flag and elastic ready.
// Depends on dgf_pkg.
`timescale 1ns / 1ps

module dgf_cell
   import dgf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  dgf_word_type in_word,
   output logic         out_valid,
   input  logic         out_ready,
   output dgf_word_type out_word
);

   logic         valid_ff;
   logic         valid_in;
   dgf_word_type word_ff;
   dgf_word_type word_in;
   logic [BCD_W-1:0] adj;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[4*i +: 4] = (in_word.bcd[4*i +: 4] >= 4'd5) ?
                         in_word.bcd[4*i +: 4] + 4'd3 : in_word.bcd[4*i +: 4];
      end
      word_in.cmd = in_word.cmd;
      word_in.bcd = {adj[BCD_W-2:0], in_word.bin[NUM_W-1]};
      word_in.bin = {in_word.bin[NUM_W-2:0], 1'b0};
   end

   // take a new word whenever this slot is empty or drains this cycle
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

@@ hw/rtl/dgf_format.sv @@
// Output cell: blanks leading zeros or places the point, and registers
// the five glyph codes for the result channel.
// Depends on dgf_pkg.
`timescale 1ns / 1ps

module dgf_format
   import dgf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  dgf_word_type   in_word,
   output logic           out_valid,
   input  logic           out_ready,
   output dgf_glyphs_type out_glyphs
);

   logic           valid_ff;
   logic           valid_in;
   dgf_glyphs_type glyphs_ff;
   dgf_glyphs_type glyphs_in;
   dgf_glyphs_type int_glyphs;
   dgf_glyphs_type fix_glyphs;
   logic [DIGITS-1:0][3:0] msd;
   logic [LEAD_W-1:0]      lead;
   logic [LEAD_W:0]        src;

   // digits most significant first
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         msd[i] = in_word.bcd[4*(DIGITS-1-i) +: 4];
      end
   end

   // first nonzero digit; the units digit always shows
   always_comb begin
      if (msd[0] != 4'd0) begin
         lead = 3'd0;
      end else if (msd[1] != 4'd0) begin
         lead = 3'd1;
      end else if (msd[2] != 4'd0) begin
         lead = 3'd2;
      end else if (msd[3] != 4'd0) begin
         lead = 3'd3;
      end else begin
         lead = 3'd4;
      end
   end

   always_comb begin
      src = '0;
      for (int j = 0; j < GLYPHS; j++) begin
         src = {1'b0, lead} + 4'(j);
         int_glyphs[j] = (src < 4'(DIGITS)) ? digit_glyph(msd[src[LEAD_W-1:0]])
                                            : GLYPH_BLANK;
      end
   end

   // hundreds and above drop out; tens blank only by moving everything left
   always_comb begin
      if (msd[1] != 4'd0) begin
         fix_glyphs[0] = digit_glyph(msd[1]);
         fix_glyphs[1] = digit_glyph(msd[2]);
         fix_glyphs[2] = GLYPH_POINT;
         fix_glyphs[3] = digit_glyph(msd[3]);
         fix_glyphs[4] = digit_glyph(msd[4]);
      end else begin
         fix_glyphs[0] = digit_glyph(msd[2]);
         fix_glyphs[1] = GLYPH_POINT;
         fix_glyphs[2] = digit_glyph(msd[3]);
         fix_glyphs[3] = digit_glyph(msd[4]);
         fix_glyphs[4] = GLYPH_BLANK;
      end
   end

   assign glyphs_in = (in_word.cmd == CMD_FIXED) ? fix_glyphs : int_glyphs;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         glyphs_ff <= glyphs_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_glyphs = glyphs_ff;

endmodule

@@ hw/rtl/decimal_glyph_formatter_core.sv @@
// Decimal glyph formatter: number in, five display glyph codes out.
// Each input word passes 17 conversion cells, one per binary bit, and then the
// output register.
// Throughput: one word per cycle while results are taken; every cell holds its
// own word, so a stalled result does not stop intake until the whole chain is full.
// Reset clears all valid flags; payload registers are not reset.
`timescale 1ns / 1ps

module decimal_glyph_formatter_core
   import dgf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [16:0] number, [23:17] zero
   input  logic [0:0]  req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [4:0] glyph_0 .. [24:20] glyph_4, [31:25] zero
);

   logic [NUM_W:0]         link_valid;
   logic [NUM_W:0]         link_ready;
   dgf_word_type [NUM_W:0] link_word;
   logic [NUM_W-1:0]       number;
   dgf_glyphs_type         glyphs;

   // saturate integer mode; fixed mode keeps the raw value
   assign number = (req_tuser[0] == CMD_INT && req_tdata[NUM_W-1:0] > INT_LIMIT) ?
                   INT_LIMIT : req_tdata[NUM_W-1:0];

   assign link_valid[0]    = req_tvalid;
   assign req_tready       = link_ready[0];
   assign link_word[0].cmd = req_tuser[0];
   assign link_word[0].bcd = '0;
   assign link_word[0].bin = number;

   for (genvar g = 0; g < NUM_W; g++) begin : g_cell
      dgf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_word   (link_word[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_word  (link_word[g+1])
      );
   end

   dgf_format u_format (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (link_valid[NUM_W]),
      .in_ready   (link_ready[NUM_W]),
      .in_word    (link_word[NUM_W]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_glyphs (glyphs)
   );

   assign rsp_tdata = {7'd0, glyphs};

endmodule

@@ hw/rtl/dgf_checker.sv @@
// Port-level checks for the decimal glyph formatter core.
// Bound to decimal_glyph_formatter_core; depends on its ports only.
`timescale 1ns / 1ps

module dgf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // leftmost glyph is never blank in either mode
   a_lead_shown: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:0] != 5'd0)
      else $error("leftmost glyph blank");

   // glyph_0 and glyph_4 digit codes in 16..25; padding stays zero
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:25] == 7'd0 &&
      (rsp_tdata[4:0] == 5'd14 || (rsp_tdata[4] && rsp_tdata[3:0] <= 4'd9)) &&
      (rsp_tdata[24:20] == 5'd0 || rsp_tdata[24:20] == 5'd14 ||
       (rsp_tdata[24] && rsp_tdata[23:20] <= 4'd9)))
      else $error("illegal glyph code");

   // at most one point per word
   a_one_point: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({rsp_tdata[4:0] == 5'd14, rsp_tdata[9:5] == 5'd14,
                               rsp_tdata[14:10] == 5'd14, rsp_tdata[19:15] == 5'd14,
                               rsp_tdata[24:20] == 5'd14}))
      else $error("more than one point glyph");

endmodule

bind decimal_glyph_formatter_core dgf_checker u_dgf_checker (.*);

@@ dv/tb_top.sv @@
// Self-checking bench for decimal_glyph_formatter_core: directed and random numbers in both
// display modes, bursty sender, stalling receiver, glyph words predicted and compared in order.
// Depends on dgf_pkg and decimal_glyph_formatter_core.
`timescale 1ns / 1ps

module tb_top;
   import dgf_pkg::*;

   localparam int PIPE_DEPTH  = 18;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 730;

   typedef struct {
      logic             cmd;
      logic [NUM_W-1:0] number;
   } number_word_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;   // [16:0] number, [23:17] zero
   logic [0:0]  req_tuser   = '0;   // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;          // [4:0] glyph_0 .. [24:20] glyph_4, [31:25] zero

   number_word_type numbers_pending[$];
   dgf_glyphs_type  glyphs_due[$];

   int error_count    = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int int_words      = 0;
   int fixed_words    = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   int holdoff_left   = 0;
   int holdoff_count  = 0;
   int stall_mode     = 0;
   int stall_timer    = 0;

   decimal_glyph_formatter_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Five glyph codes for one number, leftmost glyph in the lowest slot.
   function automatic dgf_glyphs_type format_glyphs(input logic cmd,
                                                    input logic [NUM_W-1:0] number);
      int unsigned    value;
      int unsigned    digit[5];
      int             lead;
      dgf_glyphs_type glyphs;
      value = number;
      if (cmd == CMD_FIXED) begin
         digit[1] = (value / 1000) % 10;
         digit[2] = (value / 100) % 10;
         digit[3] = (value / 10) % 10;
         digit[4] = value % 10;
         if (digit[1] != 0) begin
            glyphs[0] = GLYPH_DIGIT + GLYPH_W'(digit[1]);
            glyphs[1] = GLYPH_DIGIT + GLYPH_W'(digit[2]);
            glyphs[2] = GLYPH_POINT;
            glyphs[3] = GLYPH_DIGIT + GLYPH_W'(digit[3]);
            glyphs[4] = GLYPH_DIGIT + GLYPH_W'(digit[4]);
         end else begin
            glyphs[0] = GLYPH_DIGIT + GLYPH_W'(digit[2]);
            glyphs[1] = GLYPH_POINT;
            glyphs[2] = GLYPH_DIGIT + GLYPH_W'(digit[3]);
            glyphs[3] = GLYPH_DIGIT + GLYPH_W'(digit[4]);
            glyphs[4] = GLYPH_BLANK;
         end
      end else begin
         if (value > 99999) value = 99999;
         digit[0] = value / 10000;
         digit[1] = (value / 1000) % 10;
         digit[2] = (value / 100) % 10;
         digit[3] = (value / 10) % 10;
         digit[4] = value % 10;
         // first nonzero digit leads; all zero leaves the last digit
         lead = 4;
         for (int j = 4; j >= 0; j--)
            if (digit[j] != 0) lead = j;
         for (int j = 0; j < 5; j++)
            glyphs[j] = (lead + j < 5) ? GLYPH_DIGIT + GLYPH_W'(digit[lead + j]) : GLYPH_BLANK;
      end
      return glyphs;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      error_count++;
   endtask

   task automatic queue_number(input logic cmd, input int unsigned number);
      number_word_type word;
      word.cmd    = cmd;
      word.number = NUM_W'(number);
      numbers_pending.push_back(word);
      if (cmd == CMD_FIXED) fixed_words++;
      else int_words++;
   endtask

   // Sender: bursts of random length, random gaps; no gaps while the receiver holds off.
   always @(posedge clock) begin
      number_word_type word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            glyphs_due.push_back(format_glyphs(req_tuser[0], req_tdata[NUM_W-1:0]));
            accepted_count <= accepted_count + 1;
         end
         if (gap_left > 0 && holdoff_left == 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (numbers_pending.size() > 0) begin
            word = numbers_pending.pop_front();
            req_tdata  <= {7'd0, word.number};
            req_tuser  <= word.cmd;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, twice per run, to back the pipeline up into the input.
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_count < 2 && accepted_count >= 150 + 350 * holdoff_count) begin
         holdoff_left  <= 120;
         holdoff_count <= holdoff_count + 1;
      end
   end

   // Receiver: switch at random among always ready, light stalls, alternate cycles, heavy stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_timer <= 0;
         stall_mode  <= 0;
      end else begin
         if (stall_timer == 0) begin
            stall_timer <= $urandom_range(20, 90);
            stall_mode  <= $urandom_range(0, 3);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         if (holdoff_left > 0)
            rsp_tready <= 1'b0;
         else
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 9) >= 3);
               2: rsp_tready <= stall_timer[0];
               default: rsp_tready <= ($urandom_range(0, 9) >= 7);
            endcase
      end
   end

   // Monitor: compare each glyph word against the oldest prediction.
   always @(posedge clock) begin
      dgf_glyphs_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (glyphs_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", rsp_tdata));
         end else begin
            want = glyphs_due.pop_front();
            for (int j = 0; j < GLYPHS; j++)
               if (rsp_tdata[j*GLYPH_W +: GLYPH_W] !== want[j])
                  report_mismatch($sformatf("word %0d glyph_%0d got %0d want %0d",
                                            checked_count, j,
                                            rsp_tdata[j*GLYPH_W +: GLYPH_W], want[j]));
            if (rsp_tdata[31:25] !== 7'd0)
               report_mismatch($sformatf("word %0d padding bits %b",
                                         checked_count, rsp_tdata[31:25]));
            checked_count <= checked_count + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("decimal_glyph_formatter_core: mismatch");
         $finish;
      end
   end

   initial begin
      int unsigned pick;
      int unsigned number;
      // integer mode: zero, single digits, inner zeros, saturation edge and beyond
      queue_number(CMD_INT, 0);
      queue_number(CMD_INT, 1);
      queue_number(CMD_INT, 9);
      queue_number(CMD_INT, 10);
      queue_number(CMD_INT, 10200);
      queue_number(CMD_INT, 12345);
      queue_number(CMD_INT, 10000);
      queue_number(CMD_INT, 99999);
      queue_number(CMD_INT, 100000);
      queue_number(CMD_INT, 131071);
      queue_number(CMD_INT, 65536);
      // fixed mode: tens zero and nonzero, hundreds dropped, top of range
      queue_number(CMD_FIXED, 0);
      queue_number(CMD_FIXED, 5);
      queue_number(CMD_FIXED, 99);
      queue_number(CMD_FIXED, 100);
      queue_number(CMD_FIXED, 999);
      queue_number(CMD_FIXED, 1000);
      queue_number(CMD_FIXED, 1005);
      queue_number(CMD_FIXED, 9999);
      queue_number(CMD_FIXED, 10000);
      queue_number(CMD_FIXED, 10999);
      queue_number(CMD_FIXED, 12345);
      queue_number(CMD_FIXED, 131071);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3: number = $urandom_range(0, 131071);
            4, 5:       number = $urandom_range(0, 99);
            6:          number = $urandom_range(0, 9999);
            7:          number = $urandom_range(99990, 100010);
            8:          number = $urandom_range(0, 13) * 10000 + $urandom_range(0, 999);
            default:    number = $urandom_range(0, 12) * 1000 + $urandom_range(0, 20);
         endcase
         if (number > 131071) number = 131071;
         queue_number($urandom_range(0, 1) ? CMD_FIXED : CMD_INT, number);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (numbers_pending.size() > 0 || req_tvalid || glyphs_due.size() > 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (glyphs_due.size() > 0)
         report_mismatch($sformatf("%0d glyph words never arrived", glyphs_due.size()));

      $display("covered %0d integer and %0d two-decimal numbers, %0d glyph words checked",
               int_words, fixed_words, checked_count);
      $display("receiver held off %0d times; %0d errors", holdoff_count, error_count);
      if (error_count == 0)
         $display("decimal_glyph_formatter_core: match");
      else
         $display("decimal_glyph_formatter_core: mismatch");
      $finish;
   end

endmodule
